[design/whc_pkg.sv]
//------------------------------------------------------------------------------
// whc_pkg
// Shared types, codes and defaults for the way-halting cache core.
//------------------------------------------------------------------------------
`default_nettype none
package whc_pkg;
	localparam int DEF_SETS = 64;
	localparam int DEF_WAYS = 4;
	localparam int DEF_BLOCK_BYTES = 4;
	localparam int DEF_HALT_TAG_BITS = 4;
	localparam int DEF_ADDR_BITS = 32;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_FILL  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	localparam logic [2:0] ST_READ_HIT = 3'd0;
	localparam logic [2:0] ST_WRITE_OK = 3'd1;
	localparam logic [2:0] ST_FAULT    = 3'd2;
	localparam logic [2:0] ST_MISS     = 3'd3;
	localparam logic [2:0] ST_FILLED   = 3'd4;
	localparam logic [2:0] ST_FILL_WB  = 3'd5;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] address;
		logic [7:0]  write_byte;
		logic [31:0] fill_block;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  read_data;
		logic [1:0]  hit_way;
		logic [31:0] wb_address;
		logic [31:0] wb_block;
	} rsp_t;
endpackage
`default_nettype wire

[design/whc_front.sv]
//------------------------------------------------------------------------------
// whc_front
// Accepts items, drops unused commands, and queues them for the back end.
//------------------------------------------------------------------------------
`default_nettype none
module whc_front
	import whc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire req_t in_req,
	output logic      q_valid,
	input  wire logic q_ready,
	output req_t      q_req
);
	logic [1:0] cnt_q;
	logic       rd_q;
	logic       wr_q;
	req_t       mem_q [2];
	logic       push;
	logic       pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready && (in_req.cmd != CMD_NONE);
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_req = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

[design/whc_back.sv]
//------------------------------------------------------------------------------
// whc_back
// Looks up the set, carries out read, write or fill, and registers the result.
//------------------------------------------------------------------------------
`default_nettype none
module whc_back
	import whc_pkg::*;
#(
	parameter int SETS = DEF_SETS,
	parameter int WAYS = DEF_WAYS,
	parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
	parameter int HALT_TAG_BITS = DEF_HALT_TAG_BITS,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic readonly_mode,
	input  wire logic q_valid,
	output logic      q_ready,
	input  wire req_t q_req,
	output logic      out_valid,
	input  wire logic out_ready,
	output rsp_t      out_rsp
);
	localparam int OB = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 0;
	localparam int SB = $clog2(SETS);
	localparam int WB = $clog2(WAYS);
	localparam int MT = ADDR_BITS - OB - SB - HALT_TAG_BITS;
	localparam int BW = 8 * BLOCK_BYTES;
	localparam int OW = (OB > 0) ? OB : 1;
	localparam int MW = HALT_TAG_BITS + WB + 1;

	logic [WAYS-1:0] valid_q [SETS];

	logic busy_q;
	req_t req_q;
	logic [WAYS-1:0] tag_we;
	logic [WAYS-1:0] dat_we;
	logic [MT-1:0] tag_rd [WAYS];
	logic [BW-1:0] dat_rd [WAYS];
	logic [MW-1:0] meta_rd [WAYS];
	logic [WAYS-1:0] vld;
	logic [HALT_TAG_BITS-1:0] halt_rd [WAYS];
	logic [WB-1:0] lru_rd [WAYS];
	logic [WAYS-1:0] dirty_rd;
	logic [HALT_TAG_BITS-1:0] halt_nx [WAYS];
	logic [WB-1:0] lru_nx [WAYS];
	logic [WAYS-1:0] dirty_nx;
	logic [BW-1:0] dat_wr;
	logic [SB-1:0] set_in;
	logic [SB-1:0] set_r;
	logic [HALT_TAG_BITS-1:0] halt_r;
	logic [MT-1:0] mtag_r;
	logic [OW-1:0] off_r;
	logic [ADDR_BITS-1:0] addr_r;
	logic done;
	logic hit;
	logic [WB-1:0] hway;
	logic inv_found;
	logic [WB-1:0] inv_way;
	logic zero_found;
	logic [WB-1:0] zero_way;
	logic [WB-1:0] fway;
	logic [WB-1:0] tway;
	logic touch;
	logic do_write;
	logic is_fill;
	logic [BW-1:0] hdata;
	logic [BW-1:0] fdata;
	rsp_t rsp;

	assign addr_r = req_q.address[ADDR_BITS-1:0];
	assign set_in = q_req.address[OB +: SB];
	assign set_r = addr_r[OB +: SB];
	assign halt_r = addr_r[OB+SB +: HALT_TAG_BITS];
	assign mtag_r = addr_r[OB+SB+HALT_TAG_BITS +: MT];
	generate
		if (OB > 0) begin : g_off
			assign off_r = addr_r[OW-1:0];
		end else begin : g_nooff
			assign off_r = 1'b0;
		end
	endgenerate

	assign done = busy_q && (!out_valid || out_ready);
	assign q_ready = !busy_q;
	assign is_fill = (req_q.cmd == CMD_FILL);
	assign vld = valid_q[set_r];

	// A set without any valid way has never been touched, so its counts are zero.
	genvar gw;
	generate
		for (gw = 0; gw < WAYS; gw++) begin : g_way
			whc_ram #(.WIDTH(MT), .DEPTH(SETS)) u_tag (
				.clk(clk), .we(tag_we[gw]), .waddr(set_r), .wdata(mtag_r),
				.re(q_valid && q_ready), .raddr(set_in), .rdata(tag_rd[gw])
			);
			whc_ram #(.WIDTH(BW), .DEPTH(SETS)) u_dat (
				.clk(clk), .we(dat_we[gw]), .waddr(set_r), .wdata(dat_wr),
				.re(q_valid && q_ready), .raddr(set_in), .rdata(dat_rd[gw])
			);
			whc_ram #(.WIDTH(MW), .DEPTH(SETS)) u_meta (
				.clk(clk), .we(done), .waddr(set_r),
				.wdata({dirty_nx[gw], lru_nx[gw], halt_nx[gw]}),
				.re(q_valid && q_ready), .raddr(set_in), .rdata(meta_rd[gw])
			);
			assign halt_rd[gw] = vld[gw] ? meta_rd[gw][HALT_TAG_BITS-1:0] : '0;
			assign lru_rd[gw] = (|vld) ? meta_rd[gw][HALT_TAG_BITS +: WB] : '0;
			assign dirty_rd[gw] = vld[gw] && meta_rd[gw][MW-1];
		end
	endgenerate

	always_comb begin
		hit = 1'b0;
		hway = '0;
		inv_found = 1'b0;
		inv_way = '0;
		zero_found = 1'b0;
		zero_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (halt_rd[w] == halt_r && vld[w] && tag_rd[w] == mtag_r) begin
				hit = 1'b1;
				hway = WB'(w);
			end
			if (!vld[w]) begin
				inv_found = 1'b1;
				inv_way = WB'(w);
			end
			if (lru_rd[w] == '0) begin
				zero_found = 1'b1;
				zero_way = WB'(w);
			end
		end
		fway = inv_found ? inv_way : (zero_found ? zero_way : '0);
		hdata = dat_rd[hway];
		fdata = dat_rd[fway];
		tway = is_fill ? fway : hway;
		do_write = (req_q.cmd == CMD_WRITE) && hit && !readonly_mode;
		touch = done && (is_fill || (hit && (req_q.cmd == CMD_READ || do_write)));
		dat_wr = req_q.fill_block[BW-1:0];
		if (!is_fill) begin
			dat_wr = hdata;
			dat_wr[{off_r, 3'b000} +: 8] = req_q.write_byte;
		end
		tag_we = '0;
		dat_we = '0;
		if (done && is_fill) begin
			tag_we[fway] = 1'b1;
			dat_we[fway] = 1'b1;
		end
		if (done && do_write) dat_we[hway] = 1'b1;

		for (int w = 0; w < WAYS; w++) begin
			dirty_nx[w] = dirty_rd[w];
			halt_nx[w] = halt_rd[w];
			lru_nx[w] = lru_rd[w];
			if (is_fill && WB'(w) == fway) begin
				dirty_nx[w] = 1'b0;
				halt_nx[w] = halt_r;
			end
			if (do_write && WB'(w) == hway) dirty_nx[w] = 1'b1;
			if (touch) begin
				if (WB'(w) == tway) lru_nx[w] = WB'(WAYS - 1);
				else if (lru_rd[w] > lru_rd[tway]) lru_nx[w] = lru_rd[w] - 1'b1;
			end
		end

		rsp = '0;
		if (is_fill) begin
			rsp.hit_way = 2'(fway);
			rsp.status = ST_FILLED;
			if (vld[fway] && dirty_rd[fway]) begin
				rsp.status = ST_FILL_WB;
				rsp.wb_address = 32'({tag_rd[fway], halt_rd[fway], set_r,
					{OB{1'b0}}});
				rsp.wb_block = 32'(fdata);
			end
		end else if (!hit) begin
			rsp.status = ST_MISS;
		end else begin
			rsp.hit_way = 2'(hway);
			if (req_q.cmd == CMD_READ) begin
				rsp.status = ST_READ_HIT;
				rsp.read_data = hdata[{off_r, 3'b000} +: 8];
			end else if (readonly_mode) begin
				rsp.status = ST_FAULT;
			end else begin
				rsp.status = ST_WRITE_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) req_q <= q_req;
		if (done) out_rsp <= rsp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid <= 1'b0;
			for (int s = 0; s < SETS; s++)
				valid_q[s] <= '0;
		end else begin
			if (q_valid && q_ready) busy_q <= 1'b1;
			else if (done) busy_q <= 1'b0;
			if (done) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (done && is_fill) valid_q[set_r][fway] <= 1'b1;
		end
	end
endmodule
`default_nettype wire

[design/whc_ram.sv]
//------------------------------------------------------------------------------
// whc_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none
module whc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[design/way_halting_lru_cache_core.sv]
//------------------------------------------------------------------------------
// way_halting_lru_cache_core
// Set-associative write-back byte cache with way halting and LRU counters.
//------------------------------------------------------------------------------
// Items enter on in_valid/in_ready with cmd, address, write_byte and
// fill_block. Each read, write or fill returns one result item on
// out_valid/out_ready; an item with the unused command is taken and dropped.
// A two-entry queue separates the front end from the back end. The back end
// reads the tag, data and line state RAMs in the cycle an item leaves the
// queue and completes it once the result register is free, taking no new
// item until then. When nothing stalls, an item passes the queue, the RAM
// read registers and the result register in that order. The user is to
// write the readonly_mode register on cfg_valid/cfg_ready while idle; the
// block itself does not enforce this. Reset clears the valid bits at once;
// halt tags and dirty bits of lines that are not valid, and LRU counts in
// sets with no valid line, read as zero, so no sweep is needed. When the
// receiver stalls, the result holds, the back end waits, the queue fills.
//------------------------------------------------------------------------------
`default_nettype none
module way_halting_lru_cache_core
	import whc_pkg::*;
#(
	parameter int SETS = DEF_SETS,
	parameter int WAYS = DEF_WAYS,
	parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
	parameter int HALT_TAG_BITS = DEF_HALT_TAG_BITS,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [31:0] address,
	input  wire logic [7:0]  write_byte,
	input  wire logic [31:0] fill_block,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [7:0]       read_data,
	output logic [1:0]       hit_way,
	output logic [31:0]      wb_address,
	output logic [31:0]      wb_block
);
	logic readonly_q;
	req_t in_req;
	req_t q_req;
	logic q_valid;
	logic q_ready;
	rsp_t rsp;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) readonly_q <= 1'b0;
		else if (cfg_valid) readonly_q <= cfg_data;
	end

	assign in_req = '{cmd: cmd, address: address, write_byte: write_byte,
		fill_block: fill_block};

	whc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	whc_back #(
		.SETS(SETS), .WAYS(WAYS), .BLOCK_BYTES(BLOCK_BYTES),
		.HALT_TAG_BITS(HALT_TAG_BITS), .ADDR_BITS(ADDR_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .readonly_mode(readonly_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_rsp(rsp)
	);

	assign status = rsp.status;
	assign read_data = rsp.read_data;
	assign hit_way = rsp.hit_way;
	assign wb_address = rsp.wb_address;
	assign wb_block = rsp.wb_block;
endmodule
`default_nettype wire

[design/whc_checker.sv]
//------------------------------------------------------------------------------
// whc_checker
// Port-level checks of the cache core, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none
module whc_checker
	import whc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [7:0]  read_data,
	input wire logic [31:0] wb_block
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result changed while stalled");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_FILL_WB)
		else $error("status out of range");
	a_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_READ_HIT |-> read_data == 8'd0)
		else $error("read data on non-read result");
	a_wb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_FILL_WB |-> wb_block == 32'd0)
		else $error("writeback data without writeback");
endmodule

bind way_halting_lru_cache_core whc_checker u_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.status(status), .read_data(read_data), .wb_block(wb_block)
);
`default_nettype wire

[tb/cache_checker.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// cache_checker
// Watches the request, result and register channels of the way-halting cache.
// It keeps its own copy of the tag, LRU and data state and computes the
// expected result of each accepted read, write or fill. Each accepted
// result is compared field by field with the oldest expected result.
//------------------------------------------------------------------------------
module cache_checker
	import whc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] address,
	input  logic [7:0]  write_byte,
	input  logic [31:0] fill_block,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [7:0]  read_data,
	input  logic [1:0]  hit_way,
	input  logic [31:0] wb_address,
	input  logic [31:0] wb_block,
	output int          failures,
	output int          pending,
	output int          results_seen,
	output int          writebacks_seen,
	output int          faults_seen
);
	localparam int NSETS = 64;
	localparam int NWAYS = 4;

	logic        ro_mode;
	logic        valid_q [NSETS][NWAYS];
	logic        dirty_q [NSETS][NWAYS];
	logic [19:0] mtag_q  [NSETS][NWAYS];
	logic [3:0]  htag_q  [NSETS][NWAYS];
	logic [1:0]  age_q   [NSETS][NWAYS];
	logic [31:0] data_q  [NSETS][NWAYS];
	rsp_t        expected_rsps [$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
		failures++;
	endtask

	task automatic touch_lru(input int s, input int w);
		logic [1:0] old;
		old = age_q[s][w];
		for (int i = 0; i < NWAYS; i++) begin
			if (i == w)
				age_q[s][i] = 2'(NWAYS - 1);
			else if (age_q[s][i] > old)
				age_q[s][i] = age_q[s][i] - 1'b1;
		end
	endtask

	task automatic predict_access(input req_t r);
		rsp_t        e;
		int          s;
		int          w;
		int          off;
		logic [3:0]  ht;
		logic [19:0] mt;
		logic        found;
		e = '0;
		off = int'(r.address[1:0]);
		s = int'(r.address[7:2]);
		ht = r.address[11:8];
		mt = r.address[31:12];
		found = 1'b0;
		w = 0;
		if (r.cmd == CMD_NONE)
			return;
		if (r.cmd == CMD_FILL) begin
			for (int i = NWAYS - 1; i >= 0; i--)
				if (!valid_q[s][i]) begin
					w = i;
					found = 1'b1;
				end
			if (!found) begin
				w = 0;
				for (int i = NWAYS - 1; i >= 0; i--)
					if (age_q[s][i] == 2'd0)
						w = i;
			end
			e.status = ST_FILLED;
			if (valid_q[s][w] && dirty_q[s][w]) begin
				e.status = ST_FILL_WB;
				e.wb_address = {mtag_q[s][w], htag_q[s][w], 6'(s), 2'b00};
				e.wb_block = data_q[s][w];
			end
			data_q[s][w] = r.fill_block;
			mtag_q[s][w] = mt;
			htag_q[s][w] = ht;
			valid_q[s][w] = 1'b1;
			dirty_q[s][w] = 1'b0;
			touch_lru(s, w);
			e.hit_way = 2'(w);
		end else begin
			for (int i = NWAYS - 1; i >= 0; i--)
				if (htag_q[s][i] == ht && valid_q[s][i] && mtag_q[s][i] == mt) begin
					w = i;
					found = 1'b1;
				end
			if (!found) begin
				e.status = ST_MISS;
			end else begin
				e.hit_way = 2'(w);
				if (r.cmd == CMD_READ) begin
					e.read_data = data_q[s][w][8*off +: 8];
					touch_lru(s, w);
					e.status = ST_READ_HIT;
				end else if (ro_mode) begin
					e.status = ST_FAULT;
				end else begin
					data_q[s][w][8*off +: 8] = r.write_byte;
					dirty_q[s][w] = 1'b1;
					touch_lru(s, w);
					e.status = ST_WRITE_OK;
				end
			end
		end
		expected_rsps.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		req_t r;
		if (!arst_n) begin
			ro_mode <= 1'b0;
			failures = 0;
			results_seen = 0;
			writebacks_seen = 0;
			faults_seen = 0;
			expected_rsps.delete();
			for (int s = 0; s < NSETS; s++)
				for (int w = 0; w < NWAYS; w++) begin
					valid_q[s][w] = 1'b0;
					dirty_q[s][w] = 1'b0;
					mtag_q[s][w] = '0;
					htag_q[s][w] = '0;
					age_q[s][w] = '0;
					data_q[s][w] = '0;
				end
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (status == ST_FILL_WB)
					writebacks_seen++;
				if (status == ST_FAULT)
					faults_seen++;
				if (expected_rsps.size() == 0) begin
					report("unexpected result", 32'(status), 32'd0);
				end else begin
					e = expected_rsps.pop_front();
					if (status !== e.status)
						report("status", 32'(status), 32'(e.status));
					if (read_data !== e.read_data)
						report("read_data", 32'(read_data), 32'(e.read_data));
					if (hit_way !== e.hit_way)
						report("hit_way", 32'(hit_way), 32'(e.hit_way));
					if (wb_address !== e.wb_address)
						report("wb_address", wb_address, e.wb_address);
					if (wb_block !== e.wb_block)
						report("wb_block", wb_block, e.wb_block);
				end
			end
			if (in_valid && in_ready) begin
				r.cmd = cmd;
				r.address = address;
				r.write_byte = write_byte;
				r.fill_block = fill_block;
				predict_access(r);
			end
			if (cfg_valid && cfg_ready)
				ro_mode <= cfg_data;
		end
		pending = expected_rsps.size();
	end
endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the way-halting cache core.
// Directed items cover field extremes, every command, eviction and read-only
// faults; random phases then work a small pool of blocks so that hits,
// conflicts and dirty evictions are frequent, under bursty input and stalls.
//------------------------------------------------------------------------------
module testbench;
	import whc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [31:0] address;
	logic [7:0]  write_byte;
	logic [31:0] fill_block;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [7:0]  read_data;
	logic [1:0]  hit_way;
	logic [31:0] wb_address;
	logic [31:0] wb_block;
	int          failures;
	int          pending;
	int          results_seen;
	int          writebacks_seen;
	int          faults_seen;
	int          items_sent;
	logic        hold_off;
	logic [31:0] block_pool [16];

	way_halting_lru_cache_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .address(address),
		.write_byte(write_byte), .fill_block(fill_block),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.read_data(read_data), .hit_way(hit_way), .wb_address(wb_address),
		.wb_block(wb_block)
	);

	cache_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .address(address),
		.write_byte(write_byte), .fill_block(fill_block),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.read_data(read_data), .hit_way(hit_way), .wb_address(wb_address),
		.wb_block(wb_block), .failures(failures), .pending(pending),
		.results_seen(results_seen), .writebacks_seen(writebacks_seen),
		.faults_seen(faults_seen)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic send_item(input logic [1:0] c, input logic [31:0] a,
		input logic [7:0] b, input logic [31:0] f);
		in_valid <= 1'b1;
		cmd <= c;
		address <= a;
		write_byte <= b;
		fill_block <= f;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic idle_input(input int n);
		in_valid <= 1'b0;
		repeat (n)
			@(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		while (pending != 0)
			@(posedge clk);
		in_valid <= 1'b0;
		repeat (6)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pool_address();
		logic [31:0] a;
		a = block_pool[$urandom_range(15)];
		a[1:0] = 2'($urandom_range(3));
		return a;
	endfunction

	task automatic random_phase(input int n);
		int burst;
		int pick;
		for (int i = 0; i < 16; i++) begin
			block_pool[i] = $urandom();
			block_pool[i][7:2] = 6'($urandom_range(1));
			if ($urandom_range(1))
				block_pool[i][31:12] = 20'($urandom_range(3));
		end
		while (n > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && n > 0) begin
				pick = $urandom_range(99);
				if (pick < 35)
					send_item(CMD_READ, pool_address(), 8'($urandom()), $urandom());
				else if (pick < 65)
					send_item(CMD_WRITE, pool_address(), 8'($urandom()), $urandom());
				else if (pick < 92)
					send_item(CMD_FILL, pool_address(), 8'($urandom()), $urandom());
				else if (pick < 97)
					send_item(2'($urandom_range(2)), $urandom(), 8'($urandom()),
						$urandom());
				else
					send_item(CMD_NONE, $urandom(), 8'($urandom()), $urandom());
				burst--;
				n--;
			end
			if ($urandom_range(3) != 0)
				idle_input($urandom_range(1, 8));
		end
		in_valid <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_off)
			out_ready <= 1'b0;
		else if ((items_sent / 200) % 3 == 1)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(3) != 0);
	end

	initial begin
		hold_off = 1'b0;
		wait (items_sent >= 600);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (60)
			@(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int drain;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_NONE;
		address = '0;
		write_byte = '0;
		fill_block = '0;
		items_sent = 0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b0);

		send_item(CMD_READ, 32'h0000_0000, 8'h00, 32'h0);
		send_item(CMD_WRITE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
		send_item(CMD_FILL, 32'h0000_0000, 8'h00, 32'h0000_0000);
		send_item(CMD_FILL, 32'hFFFF_FFFF, 8'h00, 32'hFFFF_FFFF);
		send_item(CMD_READ, 32'hFFFF_FFFF, 8'h00, 32'h0);
		send_item(CMD_WRITE, 32'hFFFF_FFFC, 8'hA5, 32'h0);
		send_item(CMD_READ, 32'hFFFF_FFFC, 8'h00, 32'h0);
		send_item(CMD_NONE, 32'h1234_5678, 8'h5A, 32'h5A5A_5A5A);
		for (int i = 0; i < 5; i++)
			send_item(CMD_FILL, {20'(i), 4'h3, 6'd5, 2'd0}, 8'h00, 32'h1111_1111 * (i + 1));
		send_item(CMD_WRITE, {20'd4, 4'h3, 6'd5, 2'd2}, 8'h3C, 32'h0);
		for (int i = 5; i < 9; i++)
			send_item(CMD_FILL, {20'(i), 4'h3, 6'd5, 2'd0}, 8'h00, 32'hABCD_0000 + i);
		send_item(CMD_READ, {20'd4, 4'h7, 6'd5, 2'd0}, 8'h00, 32'h0);
		send_item(CMD_FILL, 32'h0000_0000, 8'h00, 32'hDEAD_BEEF);
		in_valid <= 1'b0;
		write_mode(1'b1);
		send_item(CMD_WRITE, {20'd8, 4'h3, 6'd5, 2'd1}, 8'h77, 32'h0);
		send_item(CMD_READ, {20'd8, 4'h3, 6'd5, 2'd3}, 8'h00, 32'h0);
		in_valid <= 1'b0;
		write_mode(1'b0);

		random_phase(800);
		write_mode(1'b1);
		random_phase(400);
		write_mode(1'b0);
		random_phase(680);

		drain = 0;
		while (pending != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (10)
			@(posedge clk);
		$display("Sent %0d items; %0d results checked, %0d dirty evictions, %0d faults.",
			items_sent, results_seen, writebacks_seen, faults_seen);
		if (failures == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

[way_halting_lru_cache_core.f]
design/whc_pkg.sv
design/whc_front.sv
design/whc_back.sv
design/whc_ram.sv
design/way_halting_lru_cache_core.sv
design/whc_checker.sv
tb/cache_checker.sv
tb/testbench.sv
